// ===== rtl/crsv_pkg.sv =====
// crsv_pkg: shared types, codes, limits and the CRC-32 byte step
// for the cache record stream validator. No dependencies.
`timescale 1ns / 1ps

package crsv_pkg;

    localparam int OFFSET_WIDTH_DEF = 40;

    localparam int RSO_W  = 17;
    localparam int KLEN_W = 13;
    localparam int VLEN_W = 23;
    localparam int CNT_W  = 23;

    localparam logic [31:0] REC_MAGIC = 32'h3152_4357;
    localparam logic [31:0] TOMB_LEN  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    localparam logic [RSO_W-1:0]  RSO_RESET  = 17'd16;
    localparam logic [KLEN_W-1:0] MAXK_RESET = 13'd4096;
    localparam logic [VLEN_W-1:0] MAXV_RESET = 23'd4194304;

    // configuration register indexes
    localparam logic [1:0] REG_RECORDS_START = 2'd0;
    localparam logic [1:0] REG_MAX_KEY       = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE     = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_TOMB  = 2'd1,
        KIND_TAIL  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_HEADER = 2'd1,
        ERR_TRUNCATED  = 2'd2,
        ERR_CRC        = 2'd3
    } err_t;

    typedef struct packed {
        logic [RSO_W-1:0]  records_start_offset;
        logic [KLEN_W-1:0] max_key_length;
        logic [VLEN_W-1:0] max_value_length;
    } cfg_t;

    // result tdata width, rounded up to whole bytes
    function automatic int tdata_width(input int ow);
        int raw;
        raw = 2 + KLEN_W + VLEN_W + ow + 32 + ow + 1;
        return ((raw + 7) >> 3) << 3;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/crsv_parser.sv =====
// crsv_parser: record header capture, limit checks, CRC and result build.
// One byte per cycle. Depends on crsv_pkg.
`timescale 1ns / 1ps

module crsv_parser #(
    parameter int OFFSET_WIDTH = crsv_pkg::OFFSET_WIDTH_DEF,
    parameter int TDATA_W      = crsv_pkg::tdata_width(OFFSET_WIDTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  crsv_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  logic               in_cmd,
    input  logic [7:0]         in_byte,
    output logic               res_valid,
    output crsv_pkg::kind_t    res_kind,
    output logic [TDATA_W-1:0] res_data
);
    import crsv_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_KEY = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        field_count_reg, field_count_next;
    logic [63:0]             header_shift_reg, header_shift_next;
    logic [KLEN_W-1:0]       key_len_reg, key_len_next;
    logic [31:0]             value_len_reg, value_len_next;
    logic [31:0]             stored_check_reg, stored_check_next;
    logic [31:0]             running_crc_reg, running_crc_next;
    logic [OFFSET_WIDTH-1:0] stream_offset_reg, stream_offset_next;
    logic [OFFSET_WIDTH-1:0] value_start_reg, value_start_next;
    logic [OFFSET_WIDTH-1:0] good_length_reg, good_length_next;
    logic                    stopped_reg, stopped_next;
    err_t                    stop_code_reg, stop_code_next;

    logic [31:0]             crc_upd;
    logic [OFFSET_WIDTH-1:0] off_inc;
    logic [CNT_W-1:0]        cnt_inc;
    logic [3:0]              hdr_idx;
    logic                    is_tomb;
    logic [VLEN_W-1:0]       vlen_out;
    logic [31:0]             klen_hdr;
    logic                    hdr_bad;
    logic                    fin;
    logic [OFFSET_WIDTH-1:0] fin_voff;
    err_t                    end_err;

    err_t                    r_err;
    logic [KLEN_W-1:0]       r_klen;
    logic [VLEN_W-1:0]       r_vlen;
    logic [OFFSET_WIDTH-1:0] r_voff;
    logic [31:0]             r_crc;
    logic [OFFSET_WIDTH-1:0] r_vlength;
    logic                    r_tail;

    assign crc_upd  = crc32_byte(running_crc_reg, in_byte);
    assign off_inc  = stream_offset_reg + OFFSET_WIDTH'(1);
    assign cnt_inc  = field_count_reg + CNT_W'(1);
    assign hdr_idx  = field_count_reg[3:0];
    assign is_tomb  = (value_len_reg == TOMB_LEN);
    assign vlen_out = is_tomb ? '0 : value_len_reg[VLEN_W-1:0];
    assign klen_hdr = header_shift_reg[63:32];

    always_comb begin
        phase_next         = phase_reg;
        field_count_next   = field_count_reg;
        header_shift_next  = header_shift_reg;
        key_len_next       = key_len_reg;
        value_len_next     = value_len_reg;
        stored_check_next  = stored_check_reg;
        running_crc_next   = running_crc_reg;
        stream_offset_next = stream_offset_reg;
        value_start_next   = value_start_reg;
        good_length_next   = good_length_reg;
        stopped_next       = stopped_reg;
        stop_code_next     = stop_code_reg;

        res_valid = 1'b0;
        res_kind  = KIND_VALUE;
        r_err     = ERR_NONE;
        r_klen    = '0;
        r_vlen    = '0;
        r_voff    = '0;
        r_crc     = '0;
        r_vlength = good_length_reg;
        r_tail    = 1'b0;

        fin      = 1'b0;
        fin_voff = value_start_reg;
        hdr_bad  = 1'b0;
        end_err  = ERR_NONE;

        if (in_valid) begin
            if (in_cmd == CMD_END) begin
                if (stopped_reg) begin
                    end_err = stop_code_reg;
                end else if (phase_reg != PH_HDR || field_count_reg >= CNT_W'(4)) begin
                    end_err = ERR_TRUNCATED;
                end
                res_valid = 1'b1;
                res_kind  = KIND_END;
                r_err     = end_err;
                r_tail    = (end_err != ERR_NONE);
                // rearm with the current register values
                phase_next         = PH_HDR;
                field_count_next   = '0;
                header_shift_next  = '0;
                key_len_next       = '0;
                value_len_next     = '0;
                stored_check_next  = '0;
                running_crc_next   = CRC_INIT;
                stream_offset_next = OFFSET_WIDTH'(cfg.records_start_offset);
                value_start_next   = '0;
                good_length_next   = OFFSET_WIDTH'(cfg.records_start_offset);
                stopped_next       = 1'b0;
                stop_code_next     = ERR_NONE;
            end else if (!stopped_reg) begin
                stream_offset_next = off_inc;
                unique case (phase_reg)
                    PH_HDR: begin
                        if (!hdr_idx[3]) begin
                            header_shift_next[hdr_idx[2:0]*8 +: 8] = in_byte;
                        end else if (!hdr_idx[2]) begin
                            value_len_next[hdr_idx[1:0]*8 +: 8] = in_byte;
                        end else begin
                            stored_check_next[hdr_idx[1:0]*8 +: 8] = in_byte;
                        end
                        field_count_next = CNT_W'(hdr_idx) + CNT_W'(1);
                        if (hdr_idx == 4'd15) begin
                            hdr_bad = (header_shift_reg[31:0] != REC_MAGIC) ||
                                      (klen_hdr == 32'd0) ||
                                      (klen_hdr > 32'(cfg.max_key_length)) ||
                                      (!is_tomb &&
                                       value_len_reg > 32'(cfg.max_value_length));
                            if (hdr_bad) begin
                                stopped_next   = 1'b1;
                                stop_code_next = ERR_BAD_HEADER;
                                res_valid      = 1'b1;
                                res_kind       = KIND_TAIL;
                                r_err          = ERR_BAD_HEADER;
                                r_klen         = klen_hdr[KLEN_W-1:0];
                                r_vlen         = vlen_out;
                                r_crc          = stored_check_next;
                                r_tail         = 1'b1;
                            end else begin
                                key_len_next     = klen_hdr[KLEN_W-1:0];
                                phase_next       = PH_KEY;
                                field_count_next = '0;
                                running_crc_next = CRC_INIT;
                            end
                        end
                    end
                    PH_KEY: begin
                        running_crc_next = crc_upd;
                        field_count_next = cnt_inc;
                        if (cnt_inc >= CNT_W'(key_len_reg)) begin
                            value_start_next = off_inc;
                            if (is_tomb || value_len_reg == 32'd0) begin
                                fin      = 1'b1;
                                fin_voff = off_inc;
                            end else begin
                                phase_next       = PH_VAL;
                                field_count_next = '0;
                            end
                        end
                    end
                    PH_VAL: begin
                        running_crc_next = crc_upd;
                        field_count_next = cnt_inc;
                        if (32'(cnt_inc) >= value_len_reg) begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_HDR;
                    end
                endcase

                if (fin) begin
                    res_valid = 1'b1;
                    r_klen    = key_len_reg;
                    r_vlen    = vlen_out;
                    r_voff    = fin_voff;
                    r_crc     = stored_check_reg;
                    if (~crc_upd != stored_check_reg) begin
                        stopped_next   = 1'b1;
                        stop_code_next = ERR_CRC;
                        res_kind       = KIND_TAIL;
                        r_err          = ERR_CRC;
                        r_tail         = 1'b1;
                    end else begin
                        res_kind          = is_tomb ? KIND_TOMB : KIND_VALUE;
                        good_length_next  = off_inc;
                        r_vlength         = off_inc;
                        phase_next        = PH_HDR;
                        field_count_next  = '0;
                        header_shift_next = '0;
                        value_len_next    = '0;
                        stored_check_next = '0;
                    end
                end
            end
        end
    end

    assign res_data = TDATA_W'({r_tail, r_vlength, r_crc, r_voff, r_vlen, r_klen, r_err});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HDR;
            field_count_reg   <= '0;
            header_shift_reg  <= '0;
            key_len_reg       <= '0;
            value_len_reg     <= '0;
            stored_check_reg  <= '0;
            running_crc_reg   <= CRC_INIT;
            stream_offset_reg <= OFFSET_WIDTH'(RSO_RESET);
            value_start_reg   <= '0;
            good_length_reg   <= OFFSET_WIDTH'(RSO_RESET);
            stopped_reg       <= 1'b0;
            stop_code_reg     <= ERR_NONE;
        end else begin
            phase_reg         <= phase_next;
            field_count_reg   <= field_count_next;
            header_shift_reg  <= header_shift_next;
            key_len_reg       <= key_len_next;
            value_len_reg     <= value_len_next;
            stored_check_reg  <= stored_check_next;
            running_crc_reg   <= running_crc_next;
            stream_offset_reg <= stream_offset_next;
            value_start_reg   <= value_start_next;
            good_length_reg   <= good_length_next;
            stopped_reg       <= stopped_next;
            stop_code_reg     <= stop_code_next;
        end
    end

    // a checked header never leaves a zero key length
    a_key_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_KEY) |-> (key_len_reg != '0))
        else $error("key phase with zero key length");

    // live header capture stays inside the 16 header bytes
    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HDR && !stopped_reg) |-> (field_count_reg < CNT_W'(16)))
        else $error("header byte count out of range");

    // end of stream always reports, and rearms clean
    a_end_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_cmd == CMD_END) |-> res_valid ##1 (!stopped_reg && phase_reg == PH_HDR))
        else $error("end of stream without report or rearm");

    // once stopped, bytes are dropped silently
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_cmd == CMD_BYTE && stopped_reg) |-> !res_valid)
        else $error("result after stop");

endmodule

// ===== rtl/crsv_out_skid.sv =====
// crsv_out_skid: two-entry output register with skid stage for results.
// Generic width, no package dependency.
`timescale 1ns / 1ps

module crsv_out_skid #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             pop;

    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_ready  = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_valid;
                    out_data_reg  <= in_data;
                end
            end else if (!out_valid_reg) begin
                out_valid_reg <= in_valid;
                out_data_reg  <= in_data;
            end else if (in_valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= in_data;
            end
        end
    end

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> in_ready)
        else $error("result offered while buffer full");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled result not held in skid stage");

endmodule

// ===== rtl/cache_record_stream_validator.sv =====
// cache_record_stream_validator: top level, config registers, parser and output buffer.
// Depends on crsv_pkg, crsv_parser, crsv_out_skid.
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                         tuser
// s_       in   data_byte[7:0]                             cmd
// m_       out  err_code, key_length, value_length,        kind[1:0]
//               val_offset, record_crc, valid_length,
//               tail_rejected, zero pad to bytes
// cfg_     in   write port: cfg_wr_en, cfg_addr, cfg_wr_data
//
// Rate: one request per cycle while s_tready is high; the parser state is updated in the
//   accept cycle (CRC byte step, offset increment, length compare) and the
//   result is registered into the output stage before it shows on m_.
// Reset: synchronous, active low; registers go to their defaults, no sweep.
// Stalls: a two-entry output stage holds results; s_tready drops while its
//   second entry is occupied, even in a cycle where the head is taken.
// The start offset register takes effect at reset and at each end-of-stream
//   rearm; the length limits apply from the next header check.

module cache_record_stream_validator #(
    parameter int OFFSET_WIDTH = crsv_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // configuration write port
    input  logic                                          cfg_wr_en,
    input  logic [1:0]                                    cfg_addr,
    input  logic [crsv_pkg::VLEN_W-1:0]                   cfg_wr_data,
    // input stream
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [7:0]                                    s_tdata,  // data_byte
    input  logic                                          s_tuser,  // cmd
    // result stream
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // err_code, key_length, value_length, val_offset, record_crc,
    // valid_length, tail_rejected
    output logic [crsv_pkg::tdata_width(OFFSET_WIDTH)-1:0] m_tdata,
    output logic [1:0]                                    m_tuser   // kind
);
    import crsv_pkg::*;

    localparam int TDATA_W = tdata_width(OFFSET_WIDTH);

    cfg_t                 cfg_reg;
    logic                 accept;
    logic                 res_valid;
    kind_t                res_kind;
    logic [TDATA_W-1:0]   res_data;
    logic [TDATA_W+1:0]   buf_out;

    // configuration registers; out-of-list indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.records_start_offset <= RSO_RESET;
            cfg_reg.max_key_length       <= MAXK_RESET;
            cfg_reg.max_value_length     <= MAXV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RECORDS_START: cfg_reg.records_start_offset <= cfg_wr_data[RSO_W-1:0];
                REG_MAX_KEY:       cfg_reg.max_key_length       <= cfg_wr_data[KLEN_W-1:0];
                REG_MAX_VALUE:     cfg_reg.max_value_length     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    crsv_parser #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .TDATA_W      (TDATA_W)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (accept),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res_kind  (res_kind),
        .res_data  (res_data)
    );

    // kind rides in the top two bits through the output stage
    crsv_out_skid #(
        .WIDTH (TDATA_W + 2)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   ({res_kind, res_data}),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_out)
    );

    assign m_tdata = buf_out[TDATA_W-1:0];
    assign m_tuser = buf_out[TDATA_W+1:TDATA_W];

endmodule

// ===== tb/cache_record_stream_validator_tb.sv =====
// cache_record_stream_validator_tb: self-checking testbench for the cache record
// stream validator. Builds record streams, predicts every report, checks m_ output.
// Depends on crsv_pkg and cache_record_stream_validator.
`timescale 1ns / 1ps

module cache_record_stream_validator_tb;
    import crsv_pkg::*;

    localparam int OFFSET_W     = 40;
    localparam int RESULT_W     = crsv_pkg::tdata_width(OFFSET_W);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_LEN     = 300;   // long receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 4;     // settle time after the last report

    typedef enum logic [1:0] {
        PARSE_HEADER = 2'd0,
        PARSE_KEY    = 2'd1,
        PARSE_VALUE  = 2'd2
    } parse_state_t;

    // one expected report, at the block's field widths
    typedef struct packed {
        kind_t               kind;
        err_t                err;
        logic [KLEN_W-1:0]   klen;
        logic [VLEN_W-1:0]   vlen;
        logic [OFFSET_W-1:0] voff;
        logic [31:0]         crc;
        logic [OFFSET_W-1:0] vlength;
        logic                tail;
    } record_report_t;

    // DUT ports; every input known from time zero
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [1:0]          cfg_addr    = REG_RECORDS_START;
    logic [VLEN_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'h00;   // data_byte
    logic                s_tuser     = CMD_BYTE; // cmd
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    // err_code, key_length, value_length, val_offset, record_crc,
    // valid_length, tail_rejected
    logic [RESULT_W-1:0] m_tdata;
    logic [1:0]          m_tuser;   // kind

    cache_record_stream_validator #(.OFFSET_WIDTH(OFFSET_W)) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    record_report_t pending_reports[$];   // reports the block still owes us
    logic [7:0]     stream_q[$];          // bytes of the stream being built

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_results  = 1'b0;
    int  hold_count    = 0;
    int  cycle_count   = 0;
    int  stall_cycles  = 0;
    int  request_count = 0;
    int  mismatch_count = 0;
    int  kind_seen[4];

    // register copies, as written
    logic [RSO_W-1:0]  cfg_rso  = RSO_RESET;
    logic [KLEN_W-1:0] cfg_maxk = MAXK_RESET;
    logic [VLEN_W-1:0] cfg_maxv = MAXV_RESET;

    // parser copy
    parse_state_t        p_state;
    int unsigned         p_count;
    logic [63:0]         p_hdr;
    logic [KLEN_W-1:0]   p_klen;
    logic [31:0]         p_vlen;
    logic [31:0]         p_stored;
    logic [31:0]         p_crc;
    logic [OFFSET_W-1:0] p_offset;
    logic [OFFSET_W-1:0] p_value_start;
    logic [OFFSET_W-1:0] p_good_len;
    bit                  p_stopped;
    err_t                p_stop_code;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // reflected CRC-32, one byte, bit-serial form
    function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        logic [7:0]  d;
        c = acc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
            d = d >> 1;
        end
        return c;
    endfunction

    // back to the start of a stream; picks up the current register copies
    task automatic rearm_parser();
        p_state       = PARSE_HEADER;
        p_count       = 0;
        p_hdr         = '0;
        p_klen        = '0;
        p_vlen        = '0;
        p_stored      = '0;
        p_crc         = CRC_INIT;
        p_offset      = OFFSET_W'(cfg_rso);
        p_value_start = '0;
        p_good_len    = OFFSET_W'(cfg_rso);
        p_stopped     = 1'b0;
        p_stop_code   = ERR_NONE;
    endtask

    task automatic push_report(input kind_t kind, input err_t err, input logic [31:0] klen,
                               input logic [31:0] vlen, input logic [OFFSET_W-1:0] voff,
                               input logic [31:0] crc, input logic [OFFSET_W-1:0] vlength,
                               input logic tail);
        record_report_t r;
        r.kind    = kind;
        r.err     = err;
        r.klen    = klen[KLEN_W-1:0];
        r.vlen    = vlen[VLEN_W-1:0];
        r.voff    = voff;
        r.crc     = crc;
        r.vlength = vlength;
        r.tail    = tail;
        pending_reports = {pending_reports, r};
    endtask

    // last byte of key (empty value / tombstone) or of value
    task automatic close_record();
        bit          tomb;
        logic [31:0] vlen;
        tomb = (p_vlen == TOMB_LEN);
        vlen = tomb ? 32'd0 : p_vlen;
        if (~p_crc != p_stored) begin
            p_stopped   = 1'b1;
            p_stop_code = ERR_CRC;
            push_report(KIND_TAIL, ERR_CRC, 32'(p_klen), vlen, p_value_start, p_stored,
                        p_good_len, 1'b1);
        end else begin
            p_good_len = p_offset;
            push_report(tomb ? KIND_TOMB : KIND_VALUE, ERR_NONE, 32'(p_klen), vlen,
                        p_value_start, p_stored, p_good_len, 1'b0);
            p_state  = PARSE_HEADER;
            p_count  = 0;
            p_hdr    = '0;
            p_vlen   = '0;
            p_stored = '0;
        end
    endtask

    // advance the parser copy by one accepted request
    task automatic predict_request(input logic cmd, input logic [7:0] b);
        err_t        err;
        int unsigned n;
        logic [31:0] magic;
        logic [31:0] klen;
        if (cmd == CMD_END) begin
            err = ERR_NONE;
            if (p_stopped) err = p_stop_code;
            else if (p_state != PARSE_HEADER || p_count >= 4) err = ERR_TRUNCATED;
            push_report(KIND_END, err, 0, 0, '0, 0, p_good_len, err != ERR_NONE);
            rearm_parser();
            return;
        end
        if (p_stopped) return;   // everything after a stop is dropped

        p_offset = p_offset + 1'b1;

        if (p_state == PARSE_HEADER) begin
            n = p_count & 15;
            if (n < 8) p_hdr = p_hdr | ({56'b0, b} << (8 * n));
            else if (n < 12) p_vlen = p_vlen | ({24'b0, b} << (8 * (n - 8)));
            else p_stored = p_stored | ({24'b0, b} << (8 * (n - 12)));
            p_count = n + 1;
            if (p_count == 16) begin
                magic = p_hdr[31:0];
                klen  = p_hdr[63:32];
                if (magic != REC_MAGIC || klen == 0 || klen > 32'(cfg_maxk) ||
                    (p_vlen != TOMB_LEN && p_vlen > 32'(cfg_maxv))) begin
                    p_stopped   = 1'b1;
                    p_stop_code = ERR_BAD_HEADER;
                    push_report(KIND_TAIL, ERR_BAD_HEADER, klen,
                                (p_vlen == TOMB_LEN) ? 32'd0 : p_vlen, '0, p_stored,
                                p_good_len, 1'b1);
                end else begin
                    p_klen  = klen[KLEN_W-1:0];
                    p_state = PARSE_KEY;
                    p_count = 0;
                    p_crc   = CRC_INIT;
                end
            end
            return;
        end

        p_crc   = crc_fold_byte(p_crc, b);
        p_count = p_count + 1;
        if (p_state == PARSE_KEY) begin
            if (p_count >= p_klen) begin
                p_value_start = p_offset;
                if (p_vlen == TOMB_LEN || p_vlen == 0) close_record();
                else begin
                    p_state = PARSE_VALUE;
                    p_count = 0;
                end
            end
        end else if (p_count >= p_vlen) begin
            close_record();
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // offer one request, with random idle cycles ahead of it; valid stays high
    task automatic send_request(input logic cmd, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        request_count++;
        predict_request(cmd, b);
    endtask

    // drop valid and wait until every report has come back
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write all three registers, then an end of stream so they are in force
    task automatic program_limits(input logic [VLEN_W-1:0] rso_raw,
                                  input logic [VLEN_W-1:0] maxk_raw,
                                  input logic [VLEN_W-1:0] maxv_raw);
        wait_for_reports();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_RECORDS_START;
        cfg_wr_data <= rso_raw;
        @(posedge aclk);
        cfg_addr    <= REG_MAX_KEY;
        cfg_wr_data <= maxk_raw;
        @(posedge aclk);
        cfg_addr    <= REG_MAX_VALUE;
        cfg_wr_data <= maxv_raw;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_rso  = rso_raw[RSO_W-1:0];
        cfg_maxk = maxk_raw[KLEN_W-1:0];
        cfg_maxv = maxv_raw[VLEN_W-1:0];
        send_request(CMD_END, 8'($urandom));
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) stream_q = {stream_q, w[8*i +: 8]};
    endtask

    // append one record; lengths over the current limits get a short body only
    task automatic add_record(input logic [31:0] magic, input logic [31:0] klen,
                              input logic [31:0] vlen, input bit bad_crc);
        logic [7:0]  body[$];
        logic [7:0]  bb;
        logic [31:0] c;
        int          nkey;
        int          nval;
        nkey = (klen <= 32'(cfg_maxk)) ? int'(klen) : 3;
        nval = (vlen == TOMB_LEN) ? 0 : ((vlen <= 32'(cfg_maxv)) ? int'(vlen) : 3);
        c = CRC_INIT;
        for (int i = 0; i < nkey + nval; i++) begin
            bb = 8'($urandom);
            body = {body, bb};
            c = crc_fold_byte(c, bb);
        end
        c = ~c;
        if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
        push_word(magic);
        push_word(klen);
        push_word(vlen);
        push_word(c);
        foreach (body[i]) stream_q = {stream_q, body[i]};
    endtask

    // first n bytes of a magic: a clean end when the stream stops there
    task automatic add_partial_magic(input int n);
        for (int i = 0; i < n; i++) stream_q = {stream_q, REC_MAGIC[8*i +: 8]};
    endtask

    task automatic drop_tail(input int n);
        for (int i = 0; i < n && stream_q.size() > 0; i++) void'(stream_q.pop_back());
    endtask

    // send the built stream and close it with an end of stream
    task automatic send_stream();
        foreach (stream_q[i]) send_request(CMD_BYTE, stream_q[i]);
        send_request(CMD_END, 8'($urandom));
        stream_q.delete();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off counted here
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_results && hold_count < HOLD_LEN) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_count < 50)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        record_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            kind_seen[m_tuser]++;
            if (pending_reports.size() == 0) begin
                if (mismatch_count < 50)
                    $display("%0t: report with none expected, expected none, actual kind %0d data %h",
                             $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("kind",          64'(want.kind),    64'(m_tuser));
                check_field("err_code",      64'(want.err),     64'(m_tdata[1:0]));
                check_field("key_length",    64'(want.klen),    64'(m_tdata[14:2]));
                check_field("value_length",  64'(want.vlen),    64'(m_tdata[37:15]));
                check_field("val_offset",    64'(want.voff),    64'(m_tdata[77:38]));
                check_field("record_crc",    64'(want.crc),     64'(m_tdata[109:78]));
                check_field("valid_length",  64'(want.vlength), 64'(m_tdata[149:110]));
                check_field("tail_rejected", 64'(want.tail),    64'(m_tdata[150]));
            end
        end
    end

    // run watchdog and input stall count
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (s_tvalid && !s_tready) stall_cycles <= stall_cycles + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // value, tombstone and empty-value records, empty stream, partial magic
    task automatic test_good_records();
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);
        add_record(REC_MAGIC, 32'd2, TOMB_LEN, 1'b0);
        add_record(REC_MAGIC, 32'd3, 32'd0, 1'b0);
        stream_q = {stream_q, 8'hFF};   // data on the end request is ignored
        void'(stream_q.pop_back());
        send_stream();
        send_stream();               // nothing but the end request
        for (int n = 1; n <= 3; n++) begin
            add_record(REC_MAGIC, 32'd1, 32'd2, 1'b0);
            add_partial_magic(n);
            send_stream();
        end
    endtask

    // each header reject and a CRC mismatch, with bytes after the stop
    task automatic test_rejects();
        add_record(REC_MAGIC ^ 32'h0000_0100, 32'd1, 32'd1, 1'b0);
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);   // ignored after the stop
        send_stream();
        add_record(REC_MAGIC, 32'd0, 32'd1, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'd4097, 32'd1, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'd1, 32'd4194305, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'hFFFF_E001, 32'hFFFF_FFFE, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'd2, 32'd3, 1'b0);
        add_record(REC_MAGIC, 32'd2, 32'd3, 1'b1);
        add_record(REC_MAGIC, 32'd2, 32'd3, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'd2, TOMB_LEN, 1'b1);
        send_stream();
    endtask

    // stream ends inside header, key and value
    task automatic test_truncation();
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);
        drop_tail(14);               // four header bytes left
        send_stream();
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);
        drop_tail(3);                // fifteen header bytes left
        send_stream();
        add_record(REC_MAGIC, 32'd4, 32'd2, 1'b0);
        drop_tail(4);                // half the key
        send_stream();
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);
        add_record(REC_MAGIC, 32'd4, 32'd2, 1'b0);
        drop_tail(1);                // last value byte missing
        send_stream();
    endtask

    // register extremes, out-of-range values, bits above the register widths
    task automatic test_limit_extremes();
        program_limits(23'd65552, 23'd1, 23'd0);
        add_record(REC_MAGIC, 32'd1, 32'd0, 1'b0);
        add_record(REC_MAGIC, 32'd1, TOMB_LEN, 1'b0);
        add_record(REC_MAGIC, 32'd1, 32'd1, 1'b0);   // value over the limit
        send_stream();
        add_record(REC_MAGIC, 32'd2, 32'd0, 1'b0);   // key over the limit
        send_stream();
        // start offset all ones, key limit zero: every record is rejected
        program_limits(23'h7FFFFF, 23'h7FE000, 23'h7FFFFF);
        add_record(REC_MAGIC, 32'd1, 32'd0, 1'b0);
        send_stream();
        program_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
        add_record(REC_MAGIC, 32'd1, 32'h0080_0000, 1'b0);
        send_stream();
        add_record(REC_MAGIC, 32'd8191, 32'd0, 1'b0);
        drop_tail(8186);             // five key bytes of the longest key
        send_stream();
        // back to the defaults, high bits set above the offset and key registers
        program_limits(23'h7E0010, 23'h7FF000, 23'd4194304);
        add_record(REC_MAGIC, 32'd64, 32'd8, 1'b0);
        add_record(REC_MAGIC, 32'd1, 32'd300, 1'b0);
        send_stream();
    endtask

    // receiver holds off while short records keep coming: input must stall
    task automatic test_backpressure();
        wait_for_reports();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 12; i++) add_record(REC_MAGIC, 32'd1, TOMB_LEN, 1'b0);
        hold_results = 1'b1;
        send_stream();
        wait_for_reports();
    endtask

    task automatic pick_random_limits();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) program_limits(23'd16, 23'd4096, 23'd4194304);
        else if (sel == 1) program_limits(23'($urandom), 23'($urandom), 23'($urandom));
        else if (sel == 2) program_limits(23'd65552, 23'd1, 23'd0);
        else if (sel == 3) program_limits(23'($urandom_range(16, 65552)), 23'd0, 23'd4);
        else program_limits(23'($urandom_range(16, 65552)), 23'($urandom_range(1, 16)),
                            23'($urandom_range(0, 24)));
    endtask

    // mostly well-formed streams with random content, some broken or noise
    task automatic build_random_stream();
        int          nrec;
        int          sel;
        int          kmax;
        int          vmax;
        logic [31:0] klen;
        logic [31:0] vlen;
        nrec = $urandom_range(0, 4);
        kmax = (cfg_maxk == 0) ? 1 : ((cfg_maxk < 6) ? int'(cfg_maxk) : 6);
        vmax = (cfg_maxv < 12) ? int'(cfg_maxv) : 12;
        for (int r = 0; r < nrec; r++) begin
            sel  = $urandom_range(0, 99);
            klen = 32'($urandom_range(1, kmax));
            vlen = ($urandom_range(0, 6) == 0) ? TOMB_LEN : 32'($urandom_range(0, vmax));
            if (sel < 58) begin
                add_record(REC_MAGIC, klen, vlen, 1'b0);
            end else if (sel < 67) begin
                add_record(REC_MAGIC, klen, vlen, 1'b1);
            end else if (sel < 74) begin
                add_record(($urandom_range(0, 1) == 0) ? 32'($urandom) :
                           REC_MAGIC ^ (32'h1 << $urandom_range(0, 31)), klen, vlen, 1'b0);
            end else if (sel < 78) begin
                add_record(REC_MAGIC, 32'd0, vlen, 1'b0);
            end else if (sel < 83) begin
                add_record(REC_MAGIC, ($urandom_range(0, 1) == 0) ? 32'($urandom) :
                           32'(cfg_maxk) + 32'($urandom_range(1, 3)), vlen, 1'b0);
            end else if (sel < 88) begin
                add_record(REC_MAGIC, klen, ($urandom_range(0, 1) == 0) ?
                           (32'($urandom) | 32'h0080_0000) :
                           32'(cfg_maxv) + 32'($urandom_range(1, 3)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 20)) stream_q = {stream_q, 8'($urandom)};
            end
        end
        sel = $urandom_range(0, 9);
        if (sel < 2 && stream_q.size() > 0) drop_tail($urandom_range(1, 20));
        else if (sel == 2) add_partial_magic($urandom_range(1, 3));
    endtask

    task automatic test_random_streams(input int send_pct, input int recv_pct,
                                       input int n_requests);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = request_count + n_requests;
        while (request_count < stop_at) begin
            if ($urandom_range(0, 3) == 0) pick_random_limits();
            build_random_stream();
            send_stream();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rearm_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 45;
        test_good_records();
        test_rejects();
        test_truncation();
        test_limit_extremes();
        test_backpressure();

        test_random_streams(21, 45, 260);
        test_random_streams(45, 21, 260);
        test_random_streams(0, 0, 270);

        wait_for_reports();
        $display("Sent %0d requests; reports: %0d value, %0d tombstone, %0d rejected tail, %0d end.",
                 request_count, kind_seen[KIND_VALUE], kind_seen[KIND_TOMB],
                 kind_seen[KIND_TAIL], kind_seen[KIND_END]);
        $display("Input stalled for %0d cycles; %0d field mismatches.",
                 stall_cycles, mismatch_count);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/crsv_pkg.sv
rtl/crsv_parser.sv
rtl/crsv_out_skid.sv
rtl/cache_record_stream_validator.sv
tb/cache_record_stream_validator_tb.sv
